FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the Q-learning update unit.
// No dependencies; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only while out of reset.
`define QLU_ASSERT(name, clk, rstn, prop) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
        else $error("qlu assertion failed");

// Property checked on every edge, reset included.
`define QLU_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("qlu assertion failed");

`endif

FILE: hw/rtl/qlu_pkg.sv
// Types and constants of the Q-learning update unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qlu_pkg;

    // Item kinds
    typedef enum logic [0:0] {
        OP_UPDATE = 1'b0,
        OP_LOOKUP = 1'b1
    } qlu_op_t;

    // Register indexes on the configuration port
    localparam logic REG_LEARNING_RATE = 1'b0;
    localparam logic REG_DISCOUNT      = 1'b1;

    localparam int  COEF_W             = 17;
    localparam logic [COEF_W-1:0] LEARNING_RATE_RST = 17'd45875;
    localparam logic [COEF_W-1:0] DISCOUNT_RST      = 17'd62259;

    // Floors in Q16.16: -1.0 for the next state, -100.0 for a lookup
    localparam int NEXT_FLOOR_Q16   = -65536;
    localparam int LOOKUP_FLOOR_Q16 = -6553600;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 72;

    typedef struct packed {
        qlu_op_t            op;
        logic [5:0]         state_index;
        logic [1:0]         action_index;
        logic signed [31:0] reward;
        logic [5:0]         next_state_index;
    } qlu_item_t;

    typedef struct packed {
        logic      valid;
        qlu_item_t item;
    } qlu_head_t;

    typedef struct packed {
        logic clear_done;
    } qlu_status_t;

    typedef struct packed {
        logic               saturated;
        logic signed [31:0] best_value;
        logic [1:0]         best_action;
        logic signed [31:0] new_value;
    } qlu_result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tabular_q_learning_update_unit.sv
// An update passes the back-end sequencer's table read, greedy search, two multiply
// stages with a sum between them, and final write; a lookup ends after the read and
// search. The result transfer must complete before the next item is started.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every table row,
// during which s_tready stays low (register writes still taken).
`timescale 1ns / 1ps
`default_nettype none

module tabular_q_learning_update_unit
    import qlu_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // APB-style configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // Input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // state_index[5:0], action_index[7:6], reward[39:8], next_state_index[45:40]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic [0:0]            s_tuser,
    // Result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // new_value[31:0], best_action[33:32], best_value[65:34], saturated[66]
    output logic [OUT_DATA_W-1:0]      m_tdata
);

    logic [COEF_W-1:0] learning_rate_reg;
    logic [COEF_W-1:0] discount_reg;
    logic              cfg_write;
    qlu_status_t       status;
    qlu_head_t         head;
    logic              pop;
    qlu_result_t       result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            learning_rate_reg <= LEARNING_RATE_RST;
            discount_reg      <= DISCOUNT_RST;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LEARNING_RATE: learning_rate_reg <= pwdata[COEF_W-1:0];
                REG_DISCOUNT:      discount_reg      <= pwdata[COEF_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LEARNING_RATE: prdata = {15'd0, learning_rate_reg};
            REG_DISCOUNT:      prdata = {15'd0, discount_reg};
            default:           prdata = '0;
        endcase
    end

    qlu_front #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .head     (head),
        .pop      (pop)
    );

    qlu_back #(
        .NUM_STATES  (NUM_STATES),
        .NUM_ACTIONS (NUM_ACTIONS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .learning_rate (learning_rate_reg),
        .discount      (discount_reg),
        .head          (head),
        .pop           (pop),
        .status        (status),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .result        (result)
    );

    // Pack the result transfer
    assign m_tdata = {5'd0, result.saturated, result.best_value,
                      result.best_action, result.new_value};

endmodule

`default_nettype wire

FILE: hw/rtl/qlu_front.sv
// Front end: accepts items, reduces indices, queues them for the back end.
// Depends on qlu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qlu_front
    import qlu_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // state_index[5:0], action_index[7:6], reward[39:8], next_state_index[45:40]
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    // op[0]
    input  wire logic [0:0]           s_tuser,
    input  wire qlu_status_t          status,
    output qlu_head_t                 head,
    input  wire logic                 pop
);

    // Index reduction as small constant tables
    function automatic logic [5:0] mod_state(input logic [5:0] i);
        logic [5:0] r;
        r = '0;
        for (int k = 0; k < 64; k++) begin
            if (i == 6'(k)) r = 6'(k % NUM_STATES);
        end
        return r;
    endfunction

    function automatic logic [1:0] mod_action(input logic [1:0] i);
        logic [1:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            if (i == 2'(k)) r = 2'(k % NUM_ACTIONS);
        end
        return r;
    endfunction

    qlu_item_t  fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    qlu_item_t  in_item;
    logic       push;

    // Classify and unpack the incoming transfer
    always_comb begin
        in_item.op               = qlu_op_t'(s_tuser[0]);
        in_item.state_index      = mod_state(s_tdata[5:0]);
        in_item.action_index     = mod_action(s_tdata[7:6]);
        in_item.reward           = s_tdata[39:8];
        in_item.next_state_index = mod_state(s_tdata[45:40]);
    end

    assign s_tready = status.clear_done && (count_reg != 2'd2);
    assign push     = s_tvalid && s_tready;

    // Queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wr_ptr_reg] <= in_item;
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = fifo_reg[rd_ptr_reg];

    `QLU_ASSERT(front_no_pop_empty, aclk, aresetn, pop |-> count_reg != 2'd0)
    `QLU_ASSERT(front_count_bound, aclk, aresetn, count_reg != 2'd3)
    `QLU_ASSERT_ALWAYS(front_reset_empty, aclk, !aresetn |=> count_reg == 2'd0)

endmodule

`default_nettype wire

FILE: hw/rtl/qlu_back.sv
// Back end: Q-table memory, clearing pass, greedy search and update arithmetic.
// Depends on qlu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module qlu_back
    import qlu_pkg::*;
#(
    parameter int NUM_STATES  = 64,
    parameter int NUM_ACTIONS = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [COEF_W-1:0] learning_rate,
    input  wire logic [COEF_W-1:0] discount,
    input  wire qlu_head_t         head,
    output logic                   pop,
    output qlu_status_t            status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output qlu_result_t            result
);

    localparam int VW    = VALUE_WIDTH;
    localparam int AW    = $clog2(NUM_STATES);
    localparam int AA    = $clog2(NUM_ACTIONS);
    localparam int ROW_W = NUM_ACTIONS * VW;
    // Multiplier operand width and wide working width
    localparam int MW_A  = ((VW > 32) ? VW : 32) + 4;
    localparam int MW    = (MW_A > 64) ? 64 : MW_A;
    localparam int WW    = (VW + 24 > 66) ? VW + 24 : 66;
    localparam int PW    = MW + COEF_W + 1;

    localparam logic signed [WW-1:0] S64_MAX = {{(WW-63){1'b0}}, {63{1'b1}}};
    localparam logic signed [WW-1:0] S64_MIN = {{(WW-63){1'b1}}, {63{1'b0}}};
    localparam logic signed [WW-1:0] V_MAX   = {{(WW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [WW-1:0] V_MIN   = {{(WW-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [MW-1:0] FLOOR_NEXT   = MW'(NEXT_FLOOR_Q16);
    localparam logic signed [MW-1:0] FLOOR_LOOKUP = MW'(LOOKUP_FLOOR_Q16);

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_RD    = 7'b0000100,
        ST_MUL1  = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_MUL2  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } back_state_t;

    // Clamp to the signed 64-bit range; top bit flags a clamp
    function automatic logic [WW:0] sat64(input logic signed [WW-1:0] x);
        logic [WW:0] r;
        if (x > S64_MAX)      r = {1'b1, S64_MAX};
        else if (x < S64_MIN) r = {1'b1, S64_MIN};
        else                  r = {1'b0, x};
        return r;
    endfunction

    function automatic logic [AW-1:0] to_row(input logic [5:0] i);
        logic [AW+5:0] t;
        t = {{AW{1'b0}}, i};
        return t[AW-1:0];
    endfunction

    function automatic logic [AA-1:0] to_act(input logic [1:0] i);
        logic [AA+1:0] t;
        t = {{AA{1'b0}}, i};
        return t[AA-1:0];
    endfunction

    logic [ROW_W-1:0] mem [NUM_STATES];

    back_state_t              state_reg, state_next;
    logic [AW-1:0]            clr_cnt_reg;
    logic [ROW_W-1:0]         row_a_reg, row_b_reg, row_hold_reg;
    logic [AW-1:0]            rd_addr_a, rd_addr_b;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [ROW_W-1:0]         wr_data;
    qlu_op_t                  op_reg;
    logic [AW-1:0]            row_addr_reg;
    logic [AA-1:0]            act_reg;
    logic signed [31:0]       reward_reg;
    logic signed [MW-1:0]     bval_reg;
    logic [AA-1:0]            bidx_reg;
    logic signed [VW-1:0]     q_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [MW-1:0]     diff_reg;
    logic                     sat_reg;
    logic                     m_valid_reg;
    qlu_result_t              result_reg;

    logic signed [MW-1:0]     best_val;
    logic [AA-1:0]            best_idx;
    logic signed [MW-1:0]     lane_val;
    logic [WW:0]              r1, r2, r3, r4, r5;
    logic signed [WW-1:0]     sum_q, nq;
    logic                     clamp_flag;
    logic [ROW_W-1:0]         new_row;
    logic [AA+1:0]            bidx_ext;
    logic [AA+1:0]            best_ext;

    assign pop               = (state_reg == ST_IDLE) && head.valid && !m_valid_reg;
    assign status.clear_done = (state_reg != ST_CLEAR);
    assign rd_addr_a         = to_row(head.item.state_index);
    assign rd_addr_b         = (head.item.op == OP_LOOKUP) ? to_row(head.item.state_index)
                                                           : to_row(head.item.next_state_index);

    // Table memory: one write port, two registered read ports
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        row_a_reg <= mem[rd_addr_a];
        row_b_reg <= mem[rd_addr_b];
    end

    // Greedy search over the row read for the next state or the lookup
    always_comb begin
        best_val = (op_reg == OP_LOOKUP) ? FLOOR_LOOKUP : FLOOR_NEXT;
        best_idx = '0;
        lane_val = '0;
        for (int n = 0; n < NUM_ACTIONS; n++) begin
            lane_val = MW'($signed(row_b_reg[n*VW +: VW]));
            if (lane_val > best_val) begin
                best_val = lane_val;
                best_idx = AA'(n);
            end
        end
    end

    // Target and difference, then the final add and clamp
    always_comb begin
        r1    = sat64(WW'(prod_reg >>> 16));
        r2    = sat64(WW'(reward_reg) + $signed(r1[WW-1:0]));
        r3    = sat64($signed(r2[WW-1:0]) - WW'(q_reg));
        r4    = sat64(WW'(prod_reg >>> 16));
        r5    = sat64(WW'(q_reg) + $signed(r4[WW-1:0]));
        sum_q = $signed(r5[WW-1:0]);
        if (sum_q > V_MAX) begin
            nq = V_MAX;
            clamp_flag = 1'b1;
        end else if (sum_q < V_MIN) begin
            nq = V_MIN;
            clamp_flag = 1'b1;
        end else begin
            nq = sum_q;
            clamp_flag = 1'b0;
        end
        new_row = row_hold_reg;
        new_row[act_reg*VW +: VW] = nq[VW-1:0];
        bidx_ext = {2'b00, bidx_reg};
        best_ext = {2'b00, best_idx};
    end

    // Write port: clearing pass or the updated row
    always_comb begin
        wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_FIN);
        wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : row_addr_reg;
        wr_data = (state_reg == ST_CLEAR) ? '0 : new_row;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_cnt_reg == AW'(NUM_STATES - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (pop) state_next = ST_RD;
            ST_RD:    state_next = (op_reg == OP_LOOKUP) ? ST_IDLE : ST_MUL1;
            ST_MUL1:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_FIN;
            ST_FIN:   state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if ((state_reg == ST_RD && op_reg == OP_LOOKUP) || state_reg == ST_FIN) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            op_reg       <= head.item.op;
            row_addr_reg <= rd_addr_a;
            act_reg      <= to_act(head.item.action_index);
            reward_reg   <= head.item.reward;
        end
        if (state_reg == ST_RD) begin
            bval_reg     <= best_val;
            bidx_reg     <= best_idx;
            q_reg        <= row_a_reg[act_reg*VW +: VW];
            row_hold_reg <= row_a_reg;
        end
        if (state_reg == ST_MUL1) prod_reg <= bval_reg * $signed({1'b0, discount});
        if (state_reg == ST_SUM) begin
            diff_reg <= r3[MW-1:0];
            sat_reg  <= r1[WW] | r2[WW] | r3[WW];
        end
        if (state_reg == ST_MUL2) prod_reg <= diff_reg * $signed({1'b0, learning_rate});
        if (state_reg == ST_RD && op_reg == OP_LOOKUP) begin
            result_reg.new_value   <= '0;
            result_reg.best_action <= best_ext[1:0];
            result_reg.best_value  <= best_val[31:0];
            result_reg.saturated   <= 1'b0;
        end
        if (state_reg == ST_FIN) begin
            result_reg.new_value   <= nq[31:0];
            result_reg.best_action <= bidx_ext[1:0];
            result_reg.best_value  <= bval_reg[31:0];
            result_reg.saturated   <= sat_reg | r4[WW] | r5[WW] | clamp_flag;
        end
    end

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

    `QLU_ASSERT(back_pop_when_free, aclk, aresetn, pop |-> !m_valid_reg && head.valid)
    `QLU_ASSERT(back_no_pop_clearing, aclk, aresetn, state_reg == ST_CLEAR |-> !pop)
    `QLU_ASSERT(back_result_source, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN || state_reg == ST_RD))
    `QLU_ASSERT_ALWAYS(back_reset_clears, aclk, !aresetn |=> state_reg == ST_CLEAR)

endmodule

`default_nettype wire
